// ===== src/iopfc_pkg.sv =====
package iopfc_pkg;

  // Item kinds carried in the action field.
  typedef enum logic [1:0] {
    ACT_TICK    = 2'd0,
    ACT_TRIGGER = 2'd1,
    ACT_WRITE   = 2'd2,
    ACT_NONE    = 2'd3
  } action_e;

  // Pin function codes shared by inputs and outputs.
  localparam logic [3:0] FN_INHIBIT  = 4'd2;
  localparam logic [3:0] FN_SYSTRIG  = 4'd3;
  localparam logic [3:0] FN_DLOGTRIG = 4'd4;
  localparam logic [3:0] FN_FAULT    = 4'd5;
  localparam logic [3:0] FN_ON       = 4'd6;
  localparam logic [3:0] FN_TPULSE   = 4'd7;

  // Configuration register indexes, at byte address four times the index.
  typedef enum logic [2:0] {
    REG_DIN1_FN      = 3'd0,
    REG_DIN2_FN      = 3'd1,
    REG_DOUT1_FN     = 3'd2,
    REG_DOUT2_FN     = 3'd3,
    REG_POLARITY     = 3'd4,
    REG_USER_INHIBIT = 3'd5,
    REG_PULSE_WIDTH  = 3'd6
  } reg_idx_e;

  localparam int unsigned AddrW = 5;
  localparam logic [15:0] PulseWidthReset = 16'd10;

  // Configuration as seen by the datapath.
  typedef struct packed {
    logic [3:0]  din1_fn;
    logic [3:0]  din2_fn;
    logic [3:0]  dout1_fn;
    logic [3:0]  dout2_fn;
    logic [3:0]  polarity;
    logic        user_inhibit;
    logic [15:0] pulse_width;
  } cfg_t;

  // One input word.
  typedef struct packed {
    logic [1:0]  action;
    logic        din1_level;
    logic        din2_level;
    logic        channel_fault;
    logic        any_output_on;
    logic [31:0] now_ms;
    logic        write_pin;
    logic        write_value;
  } item_t;

  // One result word.
  typedef struct packed {
    logic dout1_level;
    logic dout2_level;
    logic din1_state;
    logic din2_state;
    logic inhibit_active;
    logic inhibit_changed;
    logic trigger_from_pin1;
    logic trigger_from_pin2;
  } result_t;

  function automatic logic is_trig_fn(logic [3:0] fn);
    return (fn == FN_SYSTRIG) || (fn == FN_DLOGTRIG);
  endfunction

endpackage

// ===== src/iopfc_if.sv =====
// Input channel: one word per item.
interface iopfc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic        din1_level;
  logic        din2_level;
  logic        channel_fault;
  logic        any_output_on;
  logic [31:0] now_ms;
  logic        write_pin;
  logic        write_value;

  modport source (
    output valid, action, din1_level, din2_level, channel_fault, any_output_on,
           now_ms, write_pin, write_value,
    input  ready
  );
  modport sink (
    input  valid, action, din1_level, din2_level, channel_fault, any_output_on,
           now_ms, write_pin, write_value,
    output ready
  );
endinterface

// Result channel: one word per item.
interface iopfc_out_if;
  logic valid;
  logic ready;
  logic dout1_level;
  logic dout2_level;
  logic din1_state;
  logic din2_state;
  logic inhibit_active;
  logic inhibit_changed;
  logic trigger_from_pin1;
  logic trigger_from_pin2;

  modport source (
    output valid, dout1_level, dout2_level, din1_state, din2_state, inhibit_active,
           inhibit_changed, trigger_from_pin1, trigger_from_pin2,
    input  ready
  );
  modport sink (
    input  valid, dout1_level, dout2_level, din1_state, din2_state, inhibit_active,
           inhibit_changed, trigger_from_pin1, trigger_from_pin2,
    output ready
  );
endinterface

// ===== src/iopfc_cfg_regs.sv =====
module iopfc_cfg_regs
  import iopfc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  cfg_t     cfg_q;
  logic     wr_en;
  reg_idx_e idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_e'(paddr[AddrW-1:2]);
  assign cfg_o  = cfg_q;

  // Register writes in the access phase; unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{pulse_width: PulseWidthReset, default: '0};
    end else if (wr_en) begin
      case (idx)
        REG_DIN1_FN:      cfg_q.din1_fn      <= pwdata[3:0];
        REG_DIN2_FN:      cfg_q.din2_fn      <= pwdata[3:0];
        REG_DOUT1_FN:     cfg_q.dout1_fn     <= pwdata[3:0];
        REG_DOUT2_FN:     cfg_q.dout2_fn     <= pwdata[3:0];
        REG_POLARITY:     cfg_q.polarity     <= pwdata[3:0];
        REG_USER_INHIBIT: cfg_q.user_inhibit <= pwdata[0];
        REG_PULSE_WIDTH:  cfg_q.pulse_width  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read data mux.
  always_comb begin
    prdata = '0;
    case (idx)
      REG_DIN1_FN:      prdata = {28'd0, cfg_q.din1_fn};
      REG_DIN2_FN:      prdata = {28'd0, cfg_q.din2_fn};
      REG_DOUT1_FN:     prdata = {28'd0, cfg_q.dout1_fn};
      REG_DOUT2_FN:     prdata = {28'd0, cfg_q.dout2_fn};
      REG_POLARITY:     prdata = {28'd0, cfg_q.polarity};
      REG_USER_INHIBIT: prdata = {31'd0, cfg_q.user_inhibit};
      REG_PULSE_WIDTH:  prdata = {16'd0, cfg_q.pulse_width};
      default:          prdata = '0;
    endcase
  end

endmodule

// ===== src/iopfc_core.sv =====
module iopfc_core
  import iopfc_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  item_t   item_i,
  input  logic    step_i,
  output result_t result_o
);

  logic [1:0]  prev_q, prev_d;
  logic [1:0]  ols_q, ols_d;
  logic        inh_q, inh_d;
  logic        fault_known_q, fault_known_d;
  logic        fault_val_q, fault_val_d;
  logic        on_known_q, on_known_d;
  logic        on_val_q, on_val_d;
  logic        pulse_q, pulse_d;
  logic [31:0] start_q, start_d;

  logic        s1, s2, inh_new, trig1, trig2, changed;
  logic        pulse_end, any_fault, any_on, on_new;
  logic [31:0] diff;
  logic [1:0]  is_tp, is_fault, is_on;

  // Input states after polarity.
  assign s1 = item_i.din1_level ^ cfg_i.polarity[0];
  assign s2 = item_i.din2_level ^ cfg_i.polarity[1];

  // Inhibit: user flag first, then input 2 over input 1.
  always_comb begin
    if (cfg_i.user_inhibit)                inh_new = 1'b1;
    else if (cfg_i.din2_fn == FN_INHIBIT)  inh_new = s2;
    else if (cfg_i.din1_fn == FN_INHIBIT)  inh_new = s1;
    else                                   inh_new = 1'b0;
  end

  assign trig1 = is_trig_fn(cfg_i.din1_fn) & s1 & ~prev_q[0];
  assign trig2 = is_trig_fn(cfg_i.din2_fn) & s2 & ~prev_q[1];

  // Pulse ends once the signed elapsed time exceeds the width.
  assign diff      = item_i.now_ms - start_q;
  assign pulse_end = pulse_q & ~diff[31] & (diff > {16'd0, cfg_i.pulse_width});

  assign is_tp    = {cfg_i.dout2_fn == FN_TPULSE, cfg_i.dout1_fn == FN_TPULSE};
  assign is_fault = {cfg_i.dout2_fn == FN_FAULT,  cfg_i.dout1_fn == FN_FAULT};
  assign is_on    = {cfg_i.dout2_fn == FN_ON,     cfg_i.dout1_fn == FN_ON};
  assign any_fault = |is_fault;
  assign any_on    = |is_on;
  assign on_new    = item_i.any_output_on & ~inh_new;
  assign changed   = inh_new != inh_q;

  // Next state for the word in the input register.
  always_comb begin
    prev_d        = prev_q;
    ols_d         = ols_q;
    inh_d         = inh_q;
    fault_known_d = fault_known_q;
    fault_val_d   = fault_val_q;
    on_known_d    = on_known_q;
    on_val_d      = on_val_q;
    pulse_d       = pulse_q;
    start_d       = start_q;
    case (action_e'(item_i.action))
      ACT_TICK: begin
        inh_d  = inh_new;
        prev_d = {s2, s1};
        if (pulse_end) begin
          ols_d   = ols_d & ~is_tp;
          pulse_d = 1'b0;
        end
        if (any_fault && (!fault_known_q || (fault_val_q != item_i.channel_fault))) begin
          fault_known_d = 1'b1;
          fault_val_d   = item_i.channel_fault;
          ols_d = (ols_d & ~is_fault) | (is_fault & {2{item_i.channel_fault}});
        end
        if (any_on && (!on_known_q || (on_val_q != on_new))) begin
          on_known_d = 1'b1;
          on_val_d   = on_new;
          ols_d = (ols_d & ~is_on) | (is_on & {2{on_new}});
        end
      end
      ACT_TRIGGER: begin
        if (|is_tp) begin
          ols_d   = ols_q | is_tp;
          pulse_d = 1'b1;
          start_d = item_i.now_ms;
        end
      end
      ACT_WRITE: begin
        ols_d[item_i.write_pin] = item_i.write_value;
      end
      default: ;
    endcase
  end

  // Result word from the updated state.
  always_comb begin
    result_o.dout1_level       = ols_d[0] ^ cfg_i.polarity[2];
    result_o.dout2_level       = ols_d[1] ^ cfg_i.polarity[3];
    result_o.din1_state        = s1;
    result_o.din2_state        = s2;
    result_o.inhibit_active    = inh_d;
    result_o.inhibit_changed   = (item_i.action == ACT_TICK) & changed;
    result_o.trigger_from_pin1 = (item_i.action == ACT_TICK) & trig1;
    result_o.trigger_from_pin2 = (item_i.action == ACT_TICK) & trig2;
  end

  // State registers advance once per processed word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q        <= '0;
      ols_q         <= '0;
      inh_q         <= 1'b0;
      fault_known_q <= 1'b0;
      fault_val_q   <= 1'b0;
      on_known_q    <= 1'b0;
      on_val_q      <= 1'b0;
      pulse_q       <= 1'b0;
      start_q       <= '0;
    end else if (step_i) begin
      prev_q        <= prev_d;
      ols_q         <= ols_d;
      inh_q         <= inh_d;
      fault_known_q <= fault_known_d;
      fault_val_q   <= fault_val_d;
      on_known_q    <= on_known_d;
      on_val_q      <= on_val_d;
      pulse_q       <= pulse_d;
      start_q       <= start_d;
    end
  end

endmodule

// ===== src/io_pin_function_controller.sv =====
// Digital I/O pin function controller for two inputs and two outputs.
// Items arrive on in_i as valid/ready words; each accepted word gives
// exactly one result word on out_o, in order.
// A word is taken into an input register, the pin logic updates the pin
// state and forms the result in one pass, and the result sits in an output
// register until the receiver takes it. out_o.valid rises once the word has
// moved through the state update into the output register, which it does
// when that register is free or draining. One word per cycle is sustained
// while the receiver takes results; the state update is combinational.
// When the receiver stalls, the output register holds its word and the
// input register still takes one more word; in_i.ready falls only while
// both are full, so the sender sees back-pressure after that.
// Configuration goes through the APB-style port (pready always high); the
// user writes it only while no words are in flight, unenforced by the block.
// Reset clears all pin state: outputs low, inhibit off, no pulse running,
// and the fault and output-on tracking unknown so the first tick drives
// those outputs. The pulse width resets to 10 ms.
module io_pin_function_controller
  import iopfc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  iopfc_in_if.sink         in_i,
  iopfc_out_if.source      out_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  cfg_t    cfg;
  item_t   item_q;
  result_t res_d, res_q;
  logic    in_valid_q, out_valid_q;
  logic    step, in_take;

  iopfc_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  iopfc_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .item_i   (item_q),
    .step_i   (step),
    .result_o (res_d)
  );

  // The held word moves on when the output register is free or draining.
  assign step     = in_valid_q & (~out_valid_q | out_o.ready);
  assign in_i.ready = ~in_valid_q | step;
  assign in_take  = in_i.valid & in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_take | (in_valid_q & ~step);
      out_valid_q <= step | (out_valid_q & ~out_o.ready);
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.action        <= in_i.action;
      item_q.din1_level    <= in_i.din1_level;
      item_q.din2_level    <= in_i.din2_level;
      item_q.channel_fault <= in_i.channel_fault;
      item_q.any_output_on <= in_i.any_output_on;
      item_q.now_ms        <= in_i.now_ms;
      item_q.write_pin     <= in_i.write_pin;
      item_q.write_value   <= in_i.write_value;
    end
    if (step) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid             = out_valid_q;
  assign out_o.dout1_level       = res_q.dout1_level;
  assign out_o.dout2_level       = res_q.dout2_level;
  assign out_o.din1_state        = res_q.din1_state;
  assign out_o.din2_state        = res_q.din2_state;
  assign out_o.inhibit_active    = res_q.inhibit_active;
  assign out_o.inhibit_changed   = res_q.inhibit_changed;
  assign out_o.trigger_from_pin1 = res_q.trigger_from_pin1;
  assign out_o.trigger_from_pin2 = res_q.trigger_from_pin2;

endmodule

// ===== src/iopfc_checker.sv =====
module iopfc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_word
);

  // A stalled result word holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> $stable(out_word))
    else $error("result word changed while stalled");

  // The input side only stalls while a result is waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready |-> out_valid)
    else $error("input stalled with empty output register");

  // A trigger from a pin needs that pin's logical state high.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && (out_word[1] || out_word[0]) |->
      (!out_word[1] || out_word[5]) && (!out_word[0] || out_word[4]))
    else $error("trigger reported with input state low");

  // No result is shown while in reset.
  assert property (@(posedge clk_i) !rst_ni |-> !out_valid)
    else $error("result valid during reset");

endmodule

bind io_pin_function_controller iopfc_checker u_iopfc_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_ready  (in_i.ready),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .out_word  ({out_o.dout1_level, out_o.dout2_level, out_o.din1_state,
               out_o.din2_state, out_o.inhibit_active, out_o.inhibit_changed,
               out_o.trigger_from_pin1, out_o.trigger_from_pin2})
);
